@@ sv/fpr_pkg.sv @@
package fpr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS = 1'b1;

  localparam logic [7:0] HEADER_RESET = 8'hFF;
  localparam logic [7:0] BROADCAST_ADDR = 8'h00;

  // controller to datapath
  typedef struct packed {
    logic start_frame;
    logic load_addr;
    logic load_len;
    logic load_cmd;
    logic store_data;
    logic emit_start;
    logic emit_next;
    logic load_out;
  } fpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hdr_match;
    logic addr_ok;
    logic len_ok;
    logic len_one;
    logic data_done;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } fpr_status_t;

endpackage

@@ sv/fpr_ctrl.sv @@
module fpr_ctrl
  import fpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  fpr_status_t status,
  output fpr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_HEADER,
    S_ADDRESS,
    S_LENGTH,
    S_COMMAND,
    S_DATA,
    S_CHECK,
    S_READ,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   parse_phase;
  logic   in_fire;

  assign parse_phase = (state != S_READ) && (state != S_LOAD);
  assign in_stall    = !parse_phase;
  assign in_fire     = in_valid && parse_phase;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_HEADER: begin
        if (in_fire && status.hdr_match) begin
          cmd.start_frame = 1'b1;
          state_next      = S_ADDRESS;
        end
      end
      S_ADDRESS: begin
        if (in_fire) begin
          if (status.addr_ok) begin
            cmd.load_addr = 1'b1;
            state_next    = S_LENGTH;
          end else begin
            state_next = S_HEADER;
          end
        end
      end
      S_LENGTH: begin
        if (in_fire) begin
          if (status.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = S_COMMAND;
          end else begin
            state_next = S_HEADER;
          end
        end
      end
      S_COMMAND: begin
        if (in_fire) begin
          cmd.load_cmd = 1'b1;
          state_next   = status.len_one ? S_CHECK : S_DATA;
        end
      end
      S_DATA: begin
        if (in_fire) begin
          cmd.store_data = 1'b1;
          if (status.data_done) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (in_fire) begin
          if (status.sum_match) begin
            cmd.emit_start = 1'b1;
            state_next     = status.len_one ? S_LOAD : S_READ;
          end else begin
            state_next = S_HEADER;
          end
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.emit_last) begin
            state_next = S_HEADER;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      default: begin
        state_next = S_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/fpr_datapath.sv @@
module fpr_datapath
  import fpr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [7:0]           rx_byte,
  input  fpr_cmd_t             cmd,
  output fpr_status_t          status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           command,
  output logic [5:0]           frame_length,
  output logic                 has_data,
  output logic [7:0]           data_byte,
  output logic [4:0]           byte_index,
  output logic                 last
);

  localparam int unsigned LW = $clog2(MAX_PAYLOAD + 2);
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0]  LEN_MAX = 8'(MAX_PAYLOAD + 1);

  logic [7:0]    header_value;
  logic [7:0]    node_address;
  logic [7:0]    running_sum;
  logic [LW-1:0] length_seen;
  logic [7:0]    command_seen;
  logic [CW-1:0] payload_count;
  logic [AW-1:0] emit_idx;
  logic [7:0]    payload_store [MAX_PAYLOAD];
  logic [7:0]    rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      node_address <= BROADCAST_ADDR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_VALUE: header_value <= cfg_data;
        REG_NODE_ADDRESS: node_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    status.hdr_match = (rx_byte == header_value);
    status.addr_ok   = (rx_byte == BROADCAST_ADDR) || (rx_byte == node_address);
    status.len_ok    = (rx_byte != 8'd0) && (rx_byte <= LEN_MAX);
    status.len_one   = (length_seen == LW'(1));
    // count after this byte, plus one, reaches the length
    status.data_done = ((LW + 1)'(payload_count) + (LW + 1)'(2)) >= (LW + 1)'(length_seen);
    status.sum_match = (running_sum == rx_byte);
    status.emit_last = status.len_one ||
                       (((LW + 1)'(emit_idx) + (LW + 1)'(2)) == (LW + 1)'(length_seen));
    status.out_free  = !out_valid || !out_stall;
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      length_seen   <= '0;
      command_seen  <= '0;
      payload_count <= '0;
      emit_idx      <= '0;
    end else begin
      if (cmd.start_frame) begin
        running_sum   <= '0;
        payload_count <= '0;
      end
      if (cmd.load_addr) begin
        running_sum <= rx_byte;
      end
      if (cmd.load_len) begin
        length_seen <= rx_byte[LW-1:0];
        running_sum <= running_sum + rx_byte;
      end
      if (cmd.load_cmd) begin
        command_seen  <= rx_byte;
        payload_count <= '0;
        running_sum   <= running_sum + rx_byte;
      end
      if (cmd.store_data) begin
        payload_count <= payload_count + CW'(1);
        running_sum   <= running_sum + rx_byte;
      end
      if (cmd.emit_start) begin
        emit_idx <= '0;
      end else if (cmd.emit_next) begin
        emit_idx <= emit_idx + AW'(1);
      end
    end
  end

  // payload buffer, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.store_data) begin
      payload_store[payload_count[AW-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[emit_idx];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      command      <= command_seen;
      frame_length <= 6'(length_seen);
      has_data     <= !status.len_one;
      data_byte    <= status.len_one ? 8'd0 : rd_data;
      byte_index   <= status.len_one ? 5'd0 : 5'(emit_idx);
      last         <= status.emit_last;
    end
  end

endmodule

@@ sv/framed_serial_receive_parser.sv @@
// framed serial receive parser
// rx channel: in_valid / in_stall carry one received byte (rx_byte) per request;
//   frames are header, address, length, command, length-1 payload bytes, checksum
// result channel: out_valid / out_stall carry one result per payload byte, or a
//   single result with has_data low for a command-only frame; last marks the end
// config port: cfg_we with cfg_index selects header_value (0) or node_address (1)
// throughput: one rx byte per cycle while parsing; the byte is taken in the
//   cycle it is offered, so a frame of n bytes needs n accepted requests
// after a good checksum byte the rx side stalls while results go out; each
//   result passes a payload buffer read state, then an output register load
//   state that waits while the output register is still held by a stall
// a command-only frame skips the read state and goes straight to the load
//   state after its checksum byte
// a bad address, length or checksum drops the frame silently
// reset: parser returns to header search, output register empties,
//   header_value goes to 0xFF and node_address to 0
// when the receiver stalls, the result holds steady and the burst pauses;
//   rx stays stalled until the last result of the frame is taken into the
//   output register
module framed_serial_receive_parser
  import fpr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // rx byte channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           command,
  output logic [5:0]           frame_length,
  output logic                 has_data,
  output logic [7:0]           data_byte,
  output logic [4:0]           byte_index,
  output logic                 last
);

  fpr_cmd_t    cmd;
  fpr_status_t status;

  // frame sequencing and result burst control
  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // checksum, frame fields, payload buffer and output register
  fpr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command      (command),
    .frame_length (frame_length),
    .has_data     (has_data),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

endmodule

@@ dv/framed_serial_receive_parser_test.sv @@
`timescale 1ns / 1ps

module framed_serial_receive_parser_test;
  import fpr_pkg::*;

  localparam int unsigned MAX_PAYLOAD   = 32;
  localparam int unsigned MAX_LENGTH    = MAX_PAYLOAD + 1;
  localparam int unsigned RANDOM_BYTES  = 290;
  localparam int unsigned SETTLE_CYCLES = 8;
  // cycles with no request moving on either side before the run is abandoned
  localparam int unsigned QUIET_LIMIT   = 2000;

  // parser position within a frame
  typedef enum logic [2:0] {
    SEEK_HEADER,
    GET_ADDRESS,
    GET_LENGTH,
    GET_COMMAND,
    GET_PAYLOAD,
    GET_CHECKSUM
  } rx_phase_t;

  // how payload bytes of a generated frame are filled
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct packed {
    logic [7:0] command;
    logic [5:0] frame_length;
    logic       has_data;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic       last;
  } parser_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           command;
  logic [5:0]           frame_length;
  logic                 has_data;
  logic [7:0]           data_byte;
  logic [4:0]           byte_index;
  logic                 last;

  framed_serial_receive_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .command(command),
    .frame_length(frame_length),
    .has_data(has_data),
    .data_byte(data_byte),
    .byte_index(byte_index),
    .last(last)
  );

  always #4 clk = ~clk;

  // predictor copy of the parser state and registers
  rx_phase_t  phase;
  logic [7:0] seen_sum;
  logic [7:0] seen_length;
  logic [7:0] seen_command;
  logic [5:0] seen_count;
  logic [7:0] payload_buf [MAX_PAYLOAD];
  logic [7:0] model_header;
  logic [7:0] model_node;

  // results of good frames, oldest first
  parser_result_t pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_parsed = 0;
  int unsigned quiet_cycles = 0;

  // pacing knobs for both sides
  bit          rx_gaps_on = 1'b0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run = 0;

  // advance the predictor by one accepted byte; returns 0 when the byte is ignored
  function automatic bit parse_byte(input logic [7:0] b);
    parser_result_t r;
    int unsigned    n;
    bit             consumed;
    consumed = 1'b1;
    case (phase)
      SEEK_HEADER: begin
        if (b == model_header) begin
          seen_sum   = 8'h00;
          seen_count = '0;
          phase      = GET_ADDRESS;
        end else begin
          consumed = 1'b0;
        end
      end
      GET_ADDRESS: begin
        // broadcast or own address, anything else drops the frame
        if (b == BROADCAST_ADDR || b == model_node) begin
          seen_sum = b;
          phase    = GET_LENGTH;
        end else begin
          phase = SEEK_HEADER;
        end
      end
      GET_LENGTH: begin
        if (b == 8'h00 || int'(b) > int'(MAX_LENGTH)) begin
          phase = SEEK_HEADER;
        end else begin
          seen_length = b;
          seen_sum    = seen_sum + b;
          phase       = GET_COMMAND;
        end
      end
      GET_COMMAND: begin
        seen_command = b;
        seen_count   = '0;
        seen_sum     = seen_sum + b;
        phase        = (seen_length == 8'd1) ? GET_CHECKSUM : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        if (int'(seen_count) < int'(MAX_PAYLOAD)) payload_buf[seen_count] = b;
        seen_count = seen_count + 6'd1;
        seen_sum   = seen_sum + b;
        if (int'(seen_count) + 1 >= int'(seen_length)) phase = GET_CHECKSUM;
      end
      GET_CHECKSUM: begin
        phase = SEEK_HEADER;
        if (seen_sum == b) begin
          n = int'(seen_length) - 1;
          if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
          r.command      = seen_command;
          r.frame_length = seen_length[5:0];
          if (n == 0) begin
            // command-only frame: one empty result
            r.has_data   = 1'b0;
            r.data_byte  = 8'h00;
            r.byte_index = '0;
            r.last       = 1'b1;
            pending_results.push_back(r);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              r.has_data   = 1'b1;
              r.data_byte  = payload_buf[i];
              r.byte_index = i[4:0];
              r.last       = (i + 1 == n);
              pending_results.push_back(r);
            end
          end
        end
      end
      default: phase = SEEK_HEADER;
    endcase
    return consumed;
  endfunction

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endfunction

  // any address that the parser must reject
  function automatic logic [7:0] wrong_address();
    logic [7:0] a;
    a = 8'($urandom_range(1, 255));
    while (a == model_node) a = 8'($urandom_range(1, 255));
    return a;
  endfunction

  function automatic logic [7:0] pick_address();
    return $urandom_range(0, 1) ? model_node : BROADCAST_ADDR;
  endfunction

  // mostly short frames, a few long ones and the occasional full-size one
  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(1, 8));
    if (r < 95) return 8'($urandom_range(9, MAX_LENGTH - 1));
    return 8'(MAX_LENGTH);
  endfunction

  task automatic set_pacing(input bit gaps, input int unsigned pct);
    rx_gaps_on = gaps;
    stall_pct  = pct;
    burst_left = 0;
  endtask

  // one rx request; valid stays high into the next call unless a gap is due
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (parse_byte(b)) bytes_parsed++;
    if (rx_gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // sender holds off until every expected result is out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // close any half-received frame so the parser is back at header search
  task automatic finish_frame();
    while (phase != SEEK_HEADER) send_byte(8'h00);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    finish_frame();
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEADER_VALUE) model_header = value;
    else model_node = value;
  endtask

  task automatic configure(input logic [7:0] header, input logic [7:0] node);
    write_register(REG_HEADER_VALUE, header);
    write_register(REG_NODE_ADDRESS, node);
  endtask

  // header, address, length, command, payload, checksum; stops early once the
  // parser has dropped the frame
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] len,
                            input logic [7:0] cmd, input fill_t fill, input bit bad_sum);
    logic [7:0] frame_bytes [$];
    logic [7:0] sum;
    logic [7:0] p;
    frame_bytes = {};
    sum = addr + len + cmd;
    frame_bytes.push_back(addr);
    frame_bytes.push_back(len);
    frame_bytes.push_back(cmd);
    if (len >= 8'd1 && int'(len) <= int'(MAX_LENGTH)) begin
      for (int unsigned k = 1; k < len; k++) begin
        case (fill)
          FILL_ZERO: p = 8'h00;
          FILL_ONES: p = 8'hFF;
          default:   p = 8'($urandom);
        endcase
        frame_bytes.push_back(p);
        sum = sum + p;
      end
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    send_byte(model_header);
    for (int k = 0; k < frame_bytes.size(); k++) begin
      if (phase == SEEK_HEADER) break;
      send_byte(frame_bytes[k]);
    end
  endtask

  // reset values, every drop reason and the command-only frame, no idling
  task automatic test_reset_defaults();
    set_pacing(1'b0, 0);
    // not a header: ignored
    send_byte(8'h00);
    // command-only frame whose command equals the header value
    send_frame(BROADCAST_ADDR, 8'd1, HEADER_RESET, FILL_ZERO, 1'b0);
    send_frame(BROADCAST_ADDR, 8'd2, 8'h00, FILL_ONES, 1'b0);
    // foreign address
    send_byte(model_header);
    send_byte(8'h01);
    // length zero and length one past the maximum
    send_frame(BROADCAST_ADDR, 8'd0, 8'h11, FILL_RANDOM, 1'b0);
    send_frame(BROADCAST_ADDR, 8'(MAX_LENGTH + 1), 8'h22, FILL_RANDOM, 1'b0);
    // checksum off
    send_frame(BROADCAST_ADDR, 8'd1, 8'h5A, FILL_RANDOM, 1'b1);
    wait_drained();
  endtask

  // several register settings, extremes first
  task automatic test_register_settings();
    logic [7:0] headers [4];
    logic [7:0] nodes [4];
    headers = '{8'h00, 8'hFF, 8'hA5, 8'h3C};
    nodes   = '{8'hFF, 8'h00, 8'h3C, 8'h01};
    set_pacing(1'b1, 30);
    for (int i = 0; i < 4; i++) begin
      configure(headers[i], nodes[i]);
      send_frame(model_node, 8'd3, 8'($urandom), FILL_RANDOM, 1'b0);
      send_frame(BROADCAST_ADDR, 8'd1, 8'($urandom), FILL_RANDOM, 1'b0);
      send_byte(model_header);
      send_byte(wrong_address());
      // full-size frame once, short ones otherwise
      send_frame(model_node, (i == 0) ? 8'(MAX_LENGTH) : 8'd2, 8'($urandom),
                 FILL_RANDOM, 1'b0);
    end
    wait_drained();
  endtask

  // mostly good frames with random content, some broken frames and noise
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned pick;
    target = bytes_parsed + RANDOM_BYTES;
    set_pacing(1'b1, 20);
    while (bytes_parsed < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        configure(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        case ($urandom_range(0, 3))
          0: set_pacing(1'b0, 0);
          1: set_pacing(1'b1, 20);
          2: set_pacing(1'b0, 50);
          default: set_pacing(1'b1, 80);
        endcase
      end else if (pick < 9) begin
        // hold the sender until the result side is empty
        wait_drained();
      end else if (pick < 15) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 30) begin
        case ($urandom_range(0, 2))
          0: begin
            send_byte(model_header);
            send_byte(wrong_address());
          end
          1: send_frame(pick_address(),
                        $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_LENGTH + 1, 255)),
                        8'($urandom), FILL_RANDOM, 1'b0);
          default: send_frame(pick_address(), pick_length(), 8'($urandom), FILL_RANDOM, 1'b1);
        endcase
      end else begin
        send_frame(pick_address(), pick_length(), 8'($urandom), FILL_RANDOM, 1'b0);
      end
    end
  endtask

  // result side stalls in runs of random level and length
  always @(negedge clk) begin
    if (rst || stall_pct == 0) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run == 0) begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_run <= $urandom_range(1, 12);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    parser_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result expected none actual cmd %0h len %0h data %0h idx %0h",
                 $time, command, frame_length, data_byte, byte_index);
      end else begin
        want = pending_results.pop_front();
        compare_field("command", want.command, command);
        compare_field("frame_length", 8'(want.frame_length), 8'(frame_length));
        compare_field("has_data", 8'(want.has_data), 8'(has_data));
        compare_field("data_byte", want.data_byte, data_byte);
        compare_field("byte_index", 8'(want.byte_index), 8'(byte_index));
        compare_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  // watchdog on cycles where no request moves on either channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[framed_serial_receive_parser] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // predictor starts from the reset state
    phase        = SEEK_HEADER;
    seen_sum     = 8'h00;
    seen_length  = 8'h00;
    seen_command = 8'h00;
    seen_count   = '0;
    model_header = HEADER_RESET;
    model_node   = 8'h00;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_settings();
    test_random_traffic();

    finish_frame();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("[framed_serial_receive_parser] OK");
    end else begin
      $display("[framed_serial_receive_parser] ERROR");
    end
    $finish;
  end

endmodule
